/* sv/conv2d_pkg.sv */
// shared constants, types and codes for the 2d convolution block
package conv2d_pkg;

    localparam int MAX_ROWS        = 64;
    localparam int MAX_COLS        = 64;
    localparam int MAX_KERNEL_ROWS = 5;
    localparam int MAX_KERNEL_COLS = 5;
    localparam int VALUE_BITS      = 16;

    localparam int ACT_W      = 2;
    localparam int ROW_W      = 6;
    localparam int COL_W      = 6;
    localparam int SUM_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam int FDIM_W = 7;
    localparam int KDIM_W = 3;

    localparam int FRAME_DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int FADDR_W      = $clog2(FRAME_DEPTH);
    localparam int KERNEL_DEPTH = MAX_KERNEL_ROWS * MAX_KERNEL_COLS;
    localparam int KADDR_W      = $clog2(KERNEL_DEPTH);

    localparam int POS_W = ((ROW_W > COL_W) ? ROW_W : COL_W) + KDIM_W + 1;

    typedef logic [ACT_W-1:0]              action_t;
    typedef logic [CFG_IDX_W-1:0]          cfg_idx_t;
    typedef logic signed [VALUE_BITS-1:0]  value_t;
    typedef logic signed [SUM_W-1:0]       sum_t;

    localparam action_t ACT_KERNEL  = 2'd0;
    localparam action_t ACT_PIXEL   = 2'd1;
    localparam action_t ACT_COMPUTE = 2'd2;

    localparam cfg_idx_t REG_FRAME_ROWS  = 2'd0;
    localparam cfg_idx_t REG_FRAME_COLS  = 2'd1;
    localparam cfg_idx_t REG_KERNEL_ROWS = 2'd2;
    localparam cfg_idx_t REG_KERNEL_COLS = 2'd3;

endpackage

/* sv/conv2d_ram.sv */
// generic single-port ram with registered read
module conv2d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/conv2d_center_border.sv */
// top level: frame and kernel stores with a sequenced window multiply-accumulate
//
// channel   direction  handshake             words
// cfg       in         cfg_we                cfg_addr, cfg_wdata
// in        in         in_valid / in_ready   action, row, col, value
// out       out        out_valid / out_ready sum, out_row, out_col
//
// weight and pixel writes take effect at the accepting edge; a compute word steps one
// window tap per cycle through the single ram port of each store, drains the read
// and product registers into the accumulator, then loads its result (an empty window skips the taps).
// stores are not cleared at reset; reset restores only state, dimensions and valid flags.
// a result waits in the output register while the next word is accepted; a new compute
// cannot load its result until the previous one has been taken.
module conv2d_center_border (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [conv2d_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [conv2d_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [conv2d_pkg::ACT_W-1:0]        action,
    input  logic [conv2d_pkg::ROW_W-1:0]        row,
    input  logic [conv2d_pkg::COL_W-1:0]        col,
    input  logic signed [conv2d_pkg::VALUE_BITS-1:0] value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [conv2d_pkg::SUM_W-1:0] sum,
    output logic [conv2d_pkg::ROW_W-1:0]        out_row,
    output logic [conv2d_pkg::COL_W-1:0]        out_col
);

    import conv2d_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN
    } state_t;

    state_t            state_reg;
    logic [FDIM_W-1:0] fr_reg;
    logic [FDIM_W-1:0] fc_reg;
    logic [KDIM_W-1:0] kr_reg;
    logic [KDIM_W-1:0] kc_reg;
    logic [ROW_W-1:0]  i_reg;
    logic [COL_W-1:0]  j_reg;
    logic [KDIM_W-1:0] k_reg;
    logic [KDIM_W-1:0] l_reg;
    logic              rd_v_reg;
    logic              prod_v_reg;
    sum_t              prod_reg;
    sum_t              acc_reg;
    logic              out_valid_reg;
    sum_t              sum_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [COL_W-1:0]  out_col_reg;

    logic                    in_accept;
    logic                    in_frame;
    logic                    start;
    logic                    empty_win;
    logic                    kernel_we;
    logic                    frame_we;
    logic signed [POS_W-1:0] r_pos;
    logic signed [POS_W-1:0] c_pos;
    logic                    rout;
    logic                    cout;
    logic [ROW_W-1:0]        rsel;
    logic [COL_W-1:0]        csel;
    logic [FADDR_W-1:0]      frame_addr;
    logic [KADDR_W-1:0]      kernel_addr;
    logic                    last_col;
    logic                    last_tap;
    logic                    out_free;
    value_t                  frame_q;
    value_t                  kernel_q;
    logic signed [2*VALUE_BITS-1:0] mul;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_accept = in_valid && in_ready;
    assign in_frame  = (FDIM_W'(row) < fr_reg) && (FDIM_W'(col) < fc_reg);
    assign start     = in_accept && (action == ACT_COMPUTE) && in_frame;
    assign empty_win = (kr_reg == '0) || (kc_reg == '0);

    assign kernel_we = in_accept && (action == ACT_KERNEL)
                       && (row < ROW_W'(MAX_KERNEL_ROWS)) && (col < COL_W'(MAX_KERNEL_COLS));
    assign frame_we  = in_accept && (action == ACT_PIXEL)
                       && (FDIM_W'(row) < FDIM_W'(MAX_ROWS))
                       && (FDIM_W'(col) < FDIM_W'(MAX_COLS));

    // window position, then the border substitution
    assign r_pos = POS_W'(i_reg) - POS_W'(kr_reg >> 1) + POS_W'(k_reg);
    assign c_pos = POS_W'(j_reg) - POS_W'(kc_reg >> 1) + POS_W'(l_reg);
    assign rout  = r_pos[POS_W-1] || (r_pos[POS_W-2:0] >= (POS_W-1)'(fr_reg));
    assign cout  = c_pos[POS_W-1] || (c_pos[POS_W-2:0] >= (POS_W-1)'(fc_reg));
    assign rsel  = rout ? i_reg : r_pos[ROW_W-1:0];
    assign csel  = cout ? j_reg : c_pos[COL_W-1:0];

    always_comb
    begin
        if (state_reg == S_RUN)
        begin
            frame_addr  = FADDR_W'(rsel) * FADDR_W'(MAX_COLS) + FADDR_W'(csel);
            kernel_addr = KADDR_W'(k_reg) * KADDR_W'(MAX_KERNEL_COLS) + KADDR_W'(l_reg);
        end
        else
        begin
            frame_addr  = FADDR_W'(row) * FADDR_W'(MAX_COLS) + FADDR_W'(col);
            kernel_addr = KADDR_W'(row) * KADDR_W'(MAX_KERNEL_COLS) + KADDR_W'(col);
        end
    end

    conv2d_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (FRAME_DEPTH)
    ) u_frame_ram (
        .clk   (clk),
        .we    (frame_we),
        .addr  (frame_addr),
        .wdata (value),
        .rdata (frame_q)
    );

    conv2d_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (KERNEL_DEPTH)
    ) u_kernel_ram (
        .clk   (clk),
        .we    (kernel_we),
        .addr  (kernel_addr),
        .wdata (value),
        .rdata (kernel_q)
    );

    assign mul      = frame_q * kernel_q;
    assign last_col = (l_reg == kc_reg - KDIM_W'(1));
    assign last_tap = last_col && (k_reg == kr_reg - KDIM_W'(1));
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fr_reg        <= FDIM_W'(MAX_ROWS);
            fc_reg        <= FDIM_W'(MAX_COLS);
            kr_reg        <= KDIM_W'(3);
            kc_reg        <= KDIM_W'(3);
            rd_v_reg      <= 1'b0;
            prod_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_FRAME_ROWS:
                    begin
                        fr_reg <= (cfg_wdata > FDIM_W'(MAX_ROWS)) ? FDIM_W'(MAX_ROWS)
                                                                  : FDIM_W'(cfg_wdata);
                    end
                    REG_FRAME_COLS:
                    begin
                        fc_reg <= (cfg_wdata > FDIM_W'(MAX_COLS)) ? FDIM_W'(MAX_COLS)
                                                                  : FDIM_W'(cfg_wdata);
                    end
                    REG_KERNEL_ROWS:
                    begin
                        kr_reg <= (cfg_wdata[KDIM_W-1:0] > KDIM_W'(MAX_KERNEL_ROWS))
                                  ? KDIM_W'(MAX_KERNEL_ROWS) : cfg_wdata[KDIM_W-1:0];
                    end
                    REG_KERNEL_COLS:
                    begin
                        kc_reg <= (cfg_wdata[KDIM_W-1:0] > KDIM_W'(MAX_KERNEL_COLS))
                                  ? KDIM_W'(MAX_KERNEL_COLS) : cfg_wdata[KDIM_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end

            rd_v_reg   <= (state_reg == S_RUN);
            prod_v_reg <= rd_v_reg;
            if (rd_v_reg)
            begin
                prod_reg <= SUM_W'(mul);
            end
            if (prod_v_reg)
            begin
                acc_reg <= acc_reg + prod_reg;
            end

            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        i_reg     <= row;
                        j_reg     <= col;
                        k_reg     <= '0;
                        l_reg     <= '0;
                        acc_reg   <= '0;
                        state_reg <= empty_win ? S_DRAIN : S_RUN;
                    end
                end
                S_RUN:
                begin
                    if (last_col)
                    begin
                        l_reg <= '0;
                        k_reg <= k_reg + KDIM_W'(1);
                    end
                    else
                    begin
                        l_reg <= l_reg + KDIM_W'(1);
                    end
                    if (last_tap)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    if (!rd_v_reg && !prod_v_reg && out_free)
                    begin
                        sum_reg       <= acc_reg;
                        out_row_reg   <= i_reg;
                        out_col_reg   <= j_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign sum       = sum_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;

endmodule

/* sv/conv2d_checker.sv */
// port-level checks for the 2d convolution block and the bind that attaches them
module conv2d_center_border_props (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                cfg_we,
    input logic [conv2d_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input logic [conv2d_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic [conv2d_pkg::ACT_W-1:0]        action,
    input logic [conv2d_pkg::ROW_W-1:0]        row,
    input logic [conv2d_pkg::COL_W-1:0]        col,
    input logic signed [conv2d_pkg::VALUE_BITS-1:0] value,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [conv2d_pkg::SUM_W-1:0] sum,
    input logic [conv2d_pkg::ROW_W-1:0]        out_row,
    input logic [conv2d_pkg::COL_W-1:0]        out_col
);

    import conv2d_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(sum) && $stable(out_row) && $stable(out_col))
        else $error("result changed while stalled");

    // a store write leaves the block ready in the next cycle
    a_write_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (action == ACT_KERNEL || action == ACT_PIXEL)
        |=> in_ready)
        else $error("store write did not return to ready");

    // a new result only appears as a busy compute finishes
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready && $past(!in_ready))
        else $error("result appeared outside the end of a compute");

endmodule

bind conv2d_center_border conv2d_center_border_props u_conv2d_checker (.*);
